[hdl/tss_pkg.sv]
// Shared types and constants of the TDMA slot scheduler.
package tss_pkg;

    localparam int MAX_NODES = 64;
    localparam int TBL_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = 7;
    localparam int DEST_W    = 8;
    localparam int ID_W      = 6;

    localparam logic [DEST_W-1:0] DEST_BCAST = 8'd255;
    localparam logic [DEST_W-1:0] DEST_NONE  = 8'd254;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_PRE_WR   = 3'd1,
        CMD_RX_START = 3'd2,
        CMD_RX_END   = 3'd3,
        CMD_TX_END   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_NODE_ID      = 2'd0,
        CFG_OWN_SLOT     = 2'd1,
        CFG_ACTIVE_NODES = 2'd2
    } cfg_idx_t;

    // Table write port
    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [DEST_W-1:0] data;
    } tbl_wr_t;

    // Request held between the table read and the state update
    typedef struct packed {
        logic [2:0]        cmd;
        logic              tx_pending;
        logic [DEST_W-1:0] dest;
        logic              preamble;
        logic              is_own;
        logic              in_range;
        logic [CNT_W-1:0]  slot_now;
    } s1_req_t;

endpackage

[hdl/tdma_slot_scheduler_unit.sv]
// Top level of the TDMA slot scheduler.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tuser cmd, s_tdata pending/dest/slot_sel
//  m_       out        m_tvalid / m_tready  m_tdata flags and slot_now
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle unless the output stalls; the table read is issued at acceptance,
// and state is updated as a request moves from the request to the result register.
// Table writes and reads happen in request order at acceptance; a request
// either writes the table or uses its read, never both in one cycle.
// Output register stalls hold the back stage, and the input stalls only
// when both stages are full.
// Reset is synchronous; the table valid bits clear at once, no sweep.
module tdma_slot_scheduler_unit
    import tss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    input  logic [15:0] s_tdata,   // [0] tx_pending, [8:1] dest, [14:9] slot_sel, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] radio_on, [1] send_start, [2] deliver_up,
                                   // [3] drop_frame, [4] rx_error, [11:5] slot_now, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [ID_W-1:0]   node_id_reg, own_slot_reg;
    logic [CNT_W-1:0]  active_reg;
    logic              accept, advance, s1_valid;
    s1_req_t           s1;
    tbl_wr_t           wr;
    logic [TBL_AW-1:0] rd_addr;
    logic [DEST_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg  <= '0;
            own_slot_reg <= '0;
            active_reg   <= CNT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NODE_ID:      node_id_reg  <= cfg_data[ID_W-1:0];
                CFG_OWN_SLOT:     own_slot_reg <= cfg_data[ID_W-1:0];
                CFG_ACTIVE_NODES: active_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !s1_valid || advance;
    assign accept   = s_tvalid && s_tready;

    tss_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cmd          (s_tuser),
        .tx_pending   (s_tdata[0]),
        .dest         (s_tdata[8:1]),
        .slot_sel     (s_tdata[14:9]),
        .own_slot     (own_slot_reg),
        .active_nodes (active_reg),
        .advance      (advance),
        .s1_valid     (s1_valid),
        .s1           (s1),
        .wr           (wr),
        .rd_addr      (rd_addr)
    );

    tss_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid),
        .s1       (s1),
        .rd_data  (rd_data),
        .node_id  (node_id_reg),
        .m_tready (m_tready),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/tss_table.sv]
// Preamble table memory with per-entry valid bits and registered read.
module tss_table
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tbl_wr_t           wr,
    input  logic              rd_en,
    input  logic [TBL_AW-1:0] rd_addr,
    output logic [DEST_W-1:0] rd_data
);

    logic [DEST_W-1:0]    mem [MAX_NODES];
    logic [MAX_NODES-1:0] valid_reg;
    logic [DEST_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Entries never written read as "nothing to send"
    assign rd_data = rd_valid_reg ? rd_data_reg : DEST_NONE;

endmodule

[hdl/tss_seq.sv]
// Front stage: slot counter, table address and write, request register.
module tss_seq
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [2:0]        cmd,
    input  logic              tx_pending,
    input  logic [DEST_W-1:0] dest,
    input  logic [ID_W-1:0]   slot_sel,
    input  logic [ID_W-1:0]   own_slot,
    input  logic [CNT_W-1:0]  active_nodes,
    input  logic              advance,
    output logic              s1_valid,
    output s1_req_t           s1,
    output tbl_wr_t           wr,
    output logic [TBL_AW-1:0] rd_addr
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;
    logic             s1_valid_reg, s1_valid_next;
    s1_req_t          s1_reg, s1_next;
    logic             is_tick, preamble;
    logic             own_ok, sel_ok;

    assign is_tick  = (cmd_t'(cmd) == CMD_TICK);
    assign preamble = is_tick && (first_reg || cnt_reg == active_nodes);
    assign own_ok   = 9'(own_slot) < 9'(MAX_NODES);
    assign sel_ok   = 9'(slot_sel) < 9'(MAX_NODES);

    always_comb begin
        cnt_next   = cnt_reg;
        first_next = first_reg;
        if (accept && is_tick) begin
            if (preamble) begin
                cnt_next   = '0;
                first_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Preamble ticks and preamble writes write the table; every accepted request also reads it
    always_comb begin
        wr.en   = 1'b0;
        wr.addr = TBL_AW'(own_slot);
        wr.data = tx_pending ? dest : DEST_NONE;
        if (accept) begin
            if (preamble) begin
                wr.en = own_ok;
            end else if (cmd_t'(cmd) == CMD_PRE_WR) begin
                wr.en   = sel_ok;
                wr.addr = TBL_AW'(slot_sel);
                wr.data = dest;
            end
        end
    end

    assign rd_addr = TBL_AW'(cnt_reg);

    always_comb begin
        s1_next            = s1_reg;
        s1_next.cmd        = cmd;
        s1_next.tx_pending = tx_pending;
        s1_next.dest       = dest;
        s1_next.preamble   = preamble;
        s1_next.is_own     = (cnt_reg == CNT_W'(own_slot));
        s1_next.in_range   = 9'(cnt_reg) < 9'(MAX_NODES);
        s1_next.slot_now   = cnt_next;
        s1_valid_next      = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            first_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

[hdl/tss_ctrl.sv]
// Back stage: radio and busy state update, result register.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s1_valid,
    input  s1_req_t           s1,
    input  logic [DEST_W-1:0] rd_data,
    input  logic [ID_W-1:0]   node_id,
    input  logic              m_tready,
    output logic              advance,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata
);

    logic radio_reg, radio_next;
    logic tx_reg, tx_next;
    logic rx_reg, rx_next;
    logic err_reg, err_next;
    logic m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;
    logic send, deliver, drop, err_out;
    logic [DEST_W-1:0] entry;
    logic addr_me;

    assign advance = s1_valid && (!m_valid_reg || m_tready);
    assign entry   = s1.in_range ? rd_data : DEST_NONE;
    assign addr_me = (s1.dest == DEST_BCAST) || (s1.dest == DEST_W'(node_id));

    always_comb begin
        radio_next = radio_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        send       = 1'b0;
        deliver    = 1'b0;
        drop       = 1'b0;
        err_out    = 1'b0;
        case (cmd_t'(s1.cmd))
            CMD_TICK: begin
                if (s1.preamble) begin
                    radio_next = 1'b1;
                end else if (s1.is_own) begin
                    if (entry != DEST_NONE) begin
                        if (s1.tx_pending && !tx_reg && !rx_reg) begin
                            tx_next    = 1'b1;
                            radio_next = 1'b1;
                            send       = 1'b1;
                        end
                    end else begin
                        radio_next = 1'b0;
                    end
                end else begin
                    radio_next = (entry == DEST_W'(node_id)) || (entry == DEST_BCAST);
                end
            end
            CMD_RX_START: begin
                if (radio_reg && !rx_reg) begin
                    rx_next  = 1'b1;
                    err_next = tx_reg;
                end
            end
            CMD_RX_END: begin
                if (rx_reg) begin
                    rx_next    = 1'b0;
                    radio_next = 1'b0;
                    err_next   = 1'b0;
                    if (addr_me) begin
                        deliver = 1'b1;
                        err_out = err_reg;
                    end else begin
                        drop = 1'b1;
                    end
                end
            end
            CMD_TX_END: begin
                if (tx_reg) begin
                    tx_next    = 1'b0;
                    radio_next = 1'b0;
                end
            end
            default: begin
                // preamble writes and unknown codes leave the state alone
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, s1.slot_now, err_out, drop, deliver, send, radio_next};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radio_reg   <= 1'b0;
            tx_reg      <= 1'b0;
            rx_reg      <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                radio_reg <= radio_next;
                tx_reg    <= tx_next;
                rx_reg    <= rx_next;
                err_reg   <= err_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/tss_checker.sv]
// Port-level checks of the slot scheduler and their binding.
module tss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result may come out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_one_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("frame both delivered and dropped");

    a_err_needs_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[2])
        else $error("rx error without delivery");

    a_send_awake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && !m_tdata[2] && !m_tdata[3])
        else $error("send with radio asleep or mixed with receive");

endmodule

bind tdma_slot_scheduler_unit tss_checker u_tss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
